// File: rtl/cut_and_bin_event_histogram_top_macros.svh
// Assertion helpers used by the histogram controller RTL.
`ifndef CUT_AND_BIN_EVENT_HISTOGRAM_TOP_MACROS_SVH
`define CUT_AND_BIN_EVENT_HISTOGRAM_TOP_MACROS_SVH

// same-cycle implication
`define CBH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CBH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/cbh_pkg.sv
`timescale 1ns / 1ps
package cbh_pkg;

  localparam int MAX_EDGES  = 16;
  localparam int NUM_DIMS   = 5;
  localparam int CNT_DEPTH  = 4096;
  localparam int EIDX_W     = $clog2(MAX_EDGES);
  localparam int EMEM_DEPTH = NUM_DIMS * MAX_EDGES;
  localparam int EADDR_W    = $clog2(EMEM_DEPTH);
  localparam int CADDR_W    = $clog2(CNT_DEPTH);
  localparam int FLAT_W     = NUM_DIMS * EIDX_W;
  localparam int DIM_W      = 3;
  localparam int SLOT_W     = 12;
  localparam int ECNT_W     = 5;

  localparam logic signed [31:0] DEG_K = 32'sd74961321;  // pi/180 in Q0.32

  localparam logic [1:0] CMD_EVENT = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [2:0] REG_PID   = 3'd0;
  localparam logic [2:0] REG_Q2    = 3'd1;
  localparam logic [2:0] REG_W2    = 3'd2;
  localparam logic [2:0] REG_YB    = 3'd3;
  localparam logic [2:0] REG_KIND  = 3'd4;
  localparam logic [2:0] REG_WPLN  = 3'd5;
  localparam logic [2:0] REG_DEG   = 3'd6;
  localparam logic [2:0] REG_ECNT  = 3'd7;

  localparam logic [1:0] RES_ZERO  = 2'd0;
  localparam logic [1:0] RES_READ  = 2'd1;
  localparam logic [1:0] RES_EVENT = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       mul;
    logic       cut;
    logic       dim_start;
    logic       edge_rd;
    logic       edge_cmp;
    logic       dim_next;
    logic       cnt_rd_ev;
    logic       cnt_rd_slot;
    logic       cnt_upd;
    logic       edge_wr;
    logic       clr_step;
    logic       out_load;
    logic [1:0] res_sel;
  } cbh_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       cut_pass;
    logic       dim_binned;
    logic       no_bins;
    logic       hit;
    logic       last_edge;
    logic       dim_last;
    logic       flat_ok;
    logic       clr_last;
  } cbh_stat_t;

endpackage

// File: rtl/cbh_ctrl.sv
`timescale 1ns / 1ps
`include "cut_and_bin_event_histogram_top_macros.svh"
module cbh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cbh_pkg::cbh_stat_t st,
  output cbh_pkg::cbh_cmd_t  cm
);
  import cbh_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_CUT  = 4'd3;
  localparam logic [3:0] S_DIM  = 4'd4;
  localparam logic [3:0] S_ERD  = 4'd5;
  localparam logic [3:0] S_ECMP = 4'd6;
  localparam logic [3:0] S_DNXT = 4'd7;
  localparam logic [3:0] S_CRD  = 4'd8;
  localparam logic [3:0] S_CUPD = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state, state_next;
  logic       clr_resp, clr_resp_next;
  logic [1:0] sel, sel_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_resp  <= 1'b0;
      sel       <= RES_ZERO;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_resp  <= clr_resp_next;
      sel       <= sel_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    cm             = '0;
    cm.res_sel     = sel;
    state_next     = state;
    clr_resp_next  = clr_resp;
    sel_next       = sel;
    in_ready       = (state == S_IDLE);
    out_valid_next = out_valid & ~out_ready;
    unique case (state)
      S_CLR: begin
        cm.clr_step = 1'b1;
        if (st.clr_last) begin
          clr_resp_next = 1'b0;
          if (clr_resp) begin
            sel_next   = RES_ZERO;
            state_next = S_OUT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cm.capture = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        unique case (st.cmd)
          CMD_EVENT: begin
            cm.mul     = 1'b1;
            state_next = S_CUT;
          end
          CMD_WRITE: begin
            cm.edge_wr = 1'b1;
            sel_next   = RES_ZERO;
            state_next = S_OUT;
          end
          CMD_READ: begin
            cm.cnt_rd_slot = 1'b1;
            sel_next       = RES_READ;
            state_next     = S_OUT;
          end
          CMD_CLEAR: begin
            clr_resp_next = 1'b1;
            state_next    = S_CLR;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_CUT: begin
        cm.cut = 1'b1;
        if (st.cut_pass) begin
          state_next = S_DIM;
        end else begin
          sel_next   = RES_ZERO;
          state_next = S_OUT;
        end
      end
      S_DIM: begin
        cm.dim_start = 1'b1;
        if (!st.dim_binned) begin
          state_next = S_DNXT;
        end else if (st.no_bins) begin
          sel_next   = RES_ZERO;
          state_next = S_OUT;
        end else begin
          state_next = S_ERD;
        end
      end
      S_ERD: begin
        cm.edge_rd = 1'b1;
        state_next = S_ECMP;
      end
      S_ECMP: begin
        cm.edge_cmp = 1'b1;
        if (st.hit) begin
          state_next = S_DNXT;
        end else if (st.last_edge) begin
          sel_next   = RES_ZERO;
          state_next = S_OUT;
        end else begin
          state_next = S_ERD;
        end
      end
      S_DNXT: begin
        cm.dim_next = 1'b1;
        state_next  = st.dim_last ? S_CRD : S_DIM;
      end
      S_CRD: begin
        if (st.flat_ok) begin
          cm.cnt_rd_ev = 1'b1;
          state_next   = S_CUPD;
        end else begin
          sel_next   = RES_ZERO;
          state_next = S_OUT;
        end
      end
      S_CUPD: begin
        cm.cnt_upd = 1'b1;
        sel_next   = RES_EVENT;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cm.out_load    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `CBH_ASSERT_IMP(a_cmp_fresh, state == S_ECMP, $past(state) == S_ERD, "edge compare without read")
  `CBH_ASSERT_IMP(a_upd_fresh, state == S_CUPD, $past(state) == S_CRD, "count update without read")
  `CBH_ASSERT_NXT(a_load_valid, cm.out_load, out_valid, "result load lost")

endmodule

// File: rtl/cbh_dp.sv
`timescale 1ns / 1ps
module cbh_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [31:0]                  cfg_data,
  input  logic [1:0]                   in_cmd,
  input  logic [cbh_pkg::DIM_W-1:0]    in_dim,
  input  logic [cbh_pkg::SLOT_W-1:0]   in_slot,
  input  logic signed [31:0]           in_edge_value,
  input  logic signed [15:0]           in_pid,
  input  logic signed [31:0]           in_w_value,
  input  logic signed [31:0]           in_yb,
  input  logic signed [31:0]           in_q2,
  input  logic signed [31:0]           in_nu,
  input  logic signed [31:0]           in_zh,
  input  logic signed [31:0]           in_pt2,
  input  logic signed [31:0]           in_phi,
  input  cbh_pkg::cbh_cmd_t            cm,
  output cbh_pkg::cbh_stat_t           st,
  output logic                         accepted,
  output logic [cbh_pkg::SLOT_W-1:0]   flat_bin,
  output logic [31:0]                  count_value
);
  import cbh_pkg::*;

  // configuration
  logic signed [15:0] pid_select;
  logic signed [31:0] q2_cut, w2_cut, yb_cut;
  logic               particle_kind, w_is_plain, phi_in_degrees;
  logic [NUM_DIMS*ECNT_W-1:0] edge_counts;

  always_ff @(posedge clk) begin
    if (rst) begin
      pid_select     <= 16'sd11;
      q2_cut         <= 32'sd65536;
      w2_cut         <= 32'sd262144;
      yb_cut         <= 32'sd55706;
      particle_kind  <= 1'b0;
      w_is_plain     <= 1'b0;
      phi_in_degrees <= 1'b0;
      edge_counts    <= 25'd2164802;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PID:  pid_select     <= cfg_data[15:0];
        REG_Q2:   q2_cut         <= cfg_data;
        REG_W2:   w2_cut         <= cfg_data;
        REG_YB:   yb_cut         <= cfg_data;
        REG_KIND: particle_kind  <= cfg_data[0];
        REG_WPLN: w_is_plain     <= cfg_data[0];
        REG_DEG:  phi_in_degrees <= cfg_data[0];
        REG_ECNT: edge_counts    <= cfg_data[NUM_DIMS*ECNT_W-1:0];
        default:  ;
      endcase
    end
  end

  // request registers
  logic [1:0]         it_cmd;
  logic [DIM_W-1:0]   it_dim;
  logic [SLOT_W-1:0]  it_slot;
  logic signed [31:0] it_edge;
  logic signed [15:0] it_pid;
  logic signed [31:0] it_w, it_yb, it_q2, it_nu, it_zh, it_pt2, it_phi;
  logic signed [63:0] wsq, phip;
  logic [63:0]        phir;

  assign phir = phip + 64'sd2147483648;

  always_ff @(posedge clk) begin
    if (cm.capture) begin
      it_cmd  <= in_cmd;
      it_dim  <= in_dim;
      it_slot <= in_slot;
      it_edge <= in_edge_value;
      it_pid  <= in_pid;
      it_w    <= in_w_value;
      it_yb   <= in_yb;
      it_q2   <= in_q2;
      it_nu   <= in_nu;
      it_zh   <= in_zh;
      it_pt2  <= in_pt2;
      it_phi  <= in_phi;
    end else if (cm.cut && phi_in_degrees) begin
      it_phi <= phir[63:32];
    end
    if (cm.mul) begin
      wsq  <= it_w * it_w;
      phip <= it_phi * DEG_K;
    end
  end

  // cuts; zero test on phi as received
  logic signed [63:0] w2_thr;
  logic               w_ok;
  assign w2_thr = {{16{w2_cut[31]}}, w2_cut, 16'h0000};
  assign w_ok   = w_is_plain ? (wsq >= w2_thr) : (it_w >= w2_cut);
  assign st.cut_pass = (it_pid == pid_select) && (it_q2 >= q2_cut) && w_ok &&
                       (it_yb <= yb_cut) && (it_nu != 32'sd0) &&
                       (!particle_kind ||
                        ((it_zh != 32'sd0) && (it_pt2 != 32'sd0) && (it_phi != 32'sd0)));

  // dimension walk
  logic [DIM_W-1:0]   d;
  logic [EIDX_W-1:0]  j, idx, nbins, nsz;
  logic [ECNT_W-1:0]  ecnt;
  logic [FLAT_W-1:0]  flat;
  logic signed [31:0] vd, prev_edge, edata;
  logic               in_range;

  always_comb begin
    case (d)
      3'd0:    vd = it_q2;
      3'd1:    vd = it_nu;
      3'd2:    vd = it_zh;
      3'd3:    vd = it_pt2;
      default: vd = it_phi;
    endcase
  end

  assign ecnt = edge_counts[ECNT_W*d +: ECNT_W];
  always_comb begin
    if (ecnt >= ECNT_W'(MAX_EDGES)) begin
      nbins = EIDX_W'(MAX_EDGES - 1);
    end else if (ecnt >= ECNT_W'(2)) begin
      nbins = EIDX_W'(ecnt - ECNT_W'(1));
    end else begin
      nbins = '0;
    end
  end
  assign nsz = (nbins == '0) ? EIDX_W'(1) : nbins;

  assign in_range      = (prev_edge < vd) && (vd < edata);
  assign st.hit        = (j != '0) && in_range;
  assign st.last_edge  = (j == nbins);
  assign st.no_bins    = (nbins == '0);
  assign st.dim_binned = (d == DIM_W'(0)) || (d == DIM_W'(1)) || particle_kind;
  assign st.dim_last   = (d == DIM_W'(NUM_DIMS - 1));
  assign st.flat_ok    = (flat < FLAT_W'(CNT_DEPTH));
  assign st.cmd        = it_cmd;

  always_ff @(posedge clk) begin
    if (cm.cut) begin
      d    <= '0;
      flat <= '0;
    end
    if (cm.dim_start) begin
      j   <= '0;
      idx <= '0;
    end
    if (cm.edge_cmp) begin
      prev_edge <= edata;
      j         <= j + EIDX_W'(1);
      if (st.hit) idx <= j - EIDX_W'(1);
    end
    if (cm.dim_next) begin
      flat <= FLAT_W'(flat * nsz) + FLAT_W'(idx);
      d    <= d + DIM_W'(1);
    end
  end

  // edge table
  logic [31:0]        edge_mem [EMEM_DEPTH];
  logic [EADDR_W-1:0] eaddr_rd, eaddr_wr;
  assign eaddr_rd = EADDR_W'(d) * EADDR_W'(MAX_EDGES) + EADDR_W'(j);
  assign eaddr_wr = EADDR_W'(it_dim) * EADDR_W'(MAX_EDGES) + EADDR_W'(it_slot[EIDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (cm.edge_wr && (it_dim < DIM_W'(NUM_DIMS)) && (it_slot < SLOT_W'(MAX_EDGES))) begin
      edge_mem[eaddr_wr] <= it_edge;
    end
    if (cm.edge_rd) edata <= edge_mem[eaddr_rd];
  end

  // counters
  logic [31:0]        cnt_mem [CNT_DEPTH];
  logic [31:0]        cdata, cinc, res_cnt;
  logic [CADDR_W-1:0] clr_addr, craddr;
  logic               slot_ok;

  assign st.clr_last = (clr_addr == CADDR_W'(CNT_DEPTH - 1));
  assign craddr      = cm.cnt_rd_ev ? flat[CADDR_W-1:0] : it_slot[CADDR_W-1:0];
  assign cinc        = (cdata == 32'hFFFF_FFFF) ? cdata : cdata + 32'd1;
  assign slot_ok     = ({1'b0, it_slot} < (SLOT_W + 1)'(CNT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cm.clr_step) begin
      clr_addr <= st.clr_last ? '0 : clr_addr + CADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cm.clr_step) begin
      cnt_mem[clr_addr] <= 32'd0;
    end else if (cm.cnt_upd) begin
      cnt_mem[flat[CADDR_W-1:0]] <= cinc;
    end
    if (cm.cnt_rd_ev || cm.cnt_rd_slot) cdata <= cnt_mem[craddr];
    if (cm.cnt_upd) res_cnt <= cinc;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cm.out_load) begin
      case (cm.res_sel)
        RES_READ: begin
          accepted    <= 1'b0;
          flat_bin    <= it_slot;
          count_value <= slot_ok ? cdata : 32'd0;
        end
        RES_EVENT: begin
          accepted    <= 1'b1;
          flat_bin    <= SLOT_W'(flat);
          count_value <= res_cnt;
        end
        default: begin
          accepted    <= 1'b0;
          flat_bin    <= '0;
          count_value <= 32'd0;
        end
      endcase
    end
  end

endmodule

// File: rtl/cut_and_bin_event_histogram_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake           Payload
// s_*      in         s_tvalid/s_tready   tuser cmd, tdata event or edge or bin request
// m_*      out        m_tvalid/m_tready   tuser accepted, tdata flat_bin, count_value
// cfg_*    in         cfg_valid/cfg_ready register index and data
//
// Event: accept, decode, cut, a start and a next step per dimension walked, count read,
// count update, result load, plus an edge read and compare per edge examined in each
// binned dimension.
// Edge write and bin read: accept, decode, result load. Clear: one counter a cycle.
// After reset a clearing pass over all 4096 counters runs before s_tready rises.
// One request at a time; a new one is taken while the result register waits.
module cut_and_bin_event_histogram_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,  // dim, slot, edge_value, pid, w_value, yb, q2, nu, zh, pt2, phi
  input  logic [1:0]   s_tuser,  // cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata,  // flat_bin, count_value
  output logic [0:0]   m_tuser,  // accepted
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import cbh_pkg::*;

  cbh_cmd_t  cm;
  cbh_stat_t st;
  logic [SLOT_W-1:0] flat_bin;
  logic [31:0]       count_value;
  logic              accepted;

  assign cfg_ready = 1'b1;

  cbh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .st        (st),
    .cm        (cm)
  );

  cbh_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_cmd        (s_tuser),
    .in_dim        (s_tdata[2:0]),
    .in_slot       (s_tdata[14:3]),
    .in_edge_value (s_tdata[46:15]),
    .in_pid        (s_tdata[62:47]),
    .in_w_value    (s_tdata[94:63]),
    .in_yb         (s_tdata[126:95]),
    .in_q2         (s_tdata[158:127]),
    .in_nu         (s_tdata[190:159]),
    .in_zh         (s_tdata[222:191]),
    .in_pt2        (s_tdata[254:223]),
    .in_phi        (s_tdata[286:255]),
    .cm            (cm),
    .st            (st),
    .accepted      (accepted),
    .flat_bin      (flat_bin),
    .count_value   (count_value)
  );

  assign m_tdata = {4'h0, count_value, flat_bin};
  assign m_tuser = accepted;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import cbh_pkg::*;

  typedef struct {
    logic [1:0]         cmd;
    logic [2:0]         dim;
    logic [11:0]        slot;
    logic signed [31:0] edge_value;
    logic signed [15:0] pid;
    logic signed [31:0] w_value, yb, q2, nu, zh, pt2, phi;
  } bin_req_t;

  typedef struct {
    logic        accepted;
    logic [11:0] flat_bin;
    logic [31:0] count_value;
  } bin_res_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [287:0] s_tdata = '0;
  logic [1:0]   s_tuser = CMD_EVENT;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [47:0]  m_tdata;
  logic [0:0]   m_tuser;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = REG_PID;
  logic [31:0]  cfg_data = '0;

  cut_and_bin_event_histogram_top uut (.*);

  // shadow state of the block
  logic signed [31:0] edge_mem [NUM_DIMS][MAX_EDGES];
  logic [31:0]        bin_mem [CNT_DEPTH];
  logic signed [15:0] pid_sel;
  logic signed [31:0] q2_min, w2_min, yb_max;
  logic               hadron, w_plain, phi_deg;
  logic [24:0]        edge_cnts;

  bin_res_t expected_counts [$];
  int       errors = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  longint   cyc = 0;
  longint   hold_until = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #(30_000_000);
    $display("cut_and_bin_event_histogram_top test failed");
    $finish;
  end

  always @(posedge clk) cyc <= cyc + 1;

  function automatic int bins_in(input int d);
    int c;
    c = edge_cnts[5*d +: 5];
    if (c > MAX_EDGES) c = MAX_EDGES;
    return (c >= 2) ? c - 1 : 0;
  endfunction

  function automatic int find_bin(input int d, input longint v);
    for (int i = 0; i < bins_in(d); i++)
      if (longint'(edge_mem[d][i]) < v && v < longint'(edge_mem[d][i+1])) return i;
    return -1;
  endfunction

  function automatic bin_res_t histogram_predict(input bin_req_t r);
    bin_res_t res;
    longint   v [NUM_DIMS];
    int       idx [NUM_DIMS];
    longint   flat, p, wsq;
    int       nv, n;
    logic     pass;
    res = '{1'b0, 12'd0, 32'd0};
    case (r.cmd)
      CMD_WRITE: if (r.dim < NUM_DIMS && r.slot < MAX_EDGES) edge_mem[r.dim][r.slot] = r.edge_value;
      CMD_READ: begin
        res.flat_bin = r.slot;
        res.count_value = bin_mem[r.slot];
      end
      CMD_CLEAR: foreach (bin_mem[i]) bin_mem[i] = '0;
      default: begin
        v[0] = r.q2; v[1] = r.nu; v[2] = r.zh; v[3] = r.pt2; v[4] = r.phi;
        wsq = longint'(r.w_value) * longint'(r.w_value);
        pass = (r.pid == pid_sel) && (v[0] >= longint'(q2_min)) && (v[1] != 0) &&
               (longint'(r.yb) <= longint'(yb_max));
        if (w_plain) pass &= wsq >= longint'(w2_min) * 65536;
        else pass &= r.w_value >= w2_min;
        if (hadron) pass &= (v[2] != 0) && (v[3] != 0) && (v[4] != 0);
        if (phi_deg) begin
          p = v[4] * longint'(DEG_K);
          v[4] = ((p + 64'sh80000000 + 64'sh4000000000000000) >>> 32) - 64'sd1073741824;
        end
        nv = hadron ? 5 : 2;
        for (int d = 0; d < NUM_DIMS; d++) begin
          idx[d] = (d < nv && pass) ? find_bin(d, v[d]) : 0;
          if (idx[d] < 0) pass = 0;
        end
        flat = 0;
        for (int d = 0; d < NUM_DIMS; d++) begin
          n = bins_in(d);
          if (n == 0) n = 1;
          flat = flat * n + (pass ? idx[d] : 0);
        end
        if (pass && flat < CNT_DEPTH) begin
          if (bin_mem[flat] != 32'hFFFFFFFF) bin_mem[flat]++;
          res = '{1'b1, flat[11:0], bin_mem[flat]};
        end
      end
    endcase
    return res;
  endfunction

  // result side: random stall, long hold-off window, scoreboard
  always @(posedge clk) begin
    bin_res_t e;
    if (rst) m_tready <= 0;
    else m_tready <= (cyc < hold_until) ? 1'b0 : ($urandom_range(99) >= stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_counts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result flat=%0d cnt=%0d", m_tdata[11:0],
                                   m_tdata[43:12]);
      end else begin
        e = expected_counts.pop_front();
        if (m_tuser[0] !== e.accepted || m_tdata[11:0] !== e.flat_bin ||
            m_tdata[43:12] !== e.count_value) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp acc=%0d flat=%0d cnt=%0d got acc=%0d flat=%0d cnt=%0d",
                     e.accepted, e.flat_bin, e.count_value, m_tuser[0], m_tdata[11:0],
                     m_tdata[43:12]);
        end
      end
    end
  end

  task automatic send_request(input bin_req_t r);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1;
    s_tuser  <= r.cmd;
    s_tdata  <= {1'b0, r.phi, r.pt2, r.zh, r.nu, r.q2, r.yb, r.w_value, r.pid,
                 r.edge_value, r.slot, r.dim};
    do @(posedge clk); while (!s_tready);
    expected_counts.push_back(histogram_predict(r));
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PID:  pid_sel   = val[15:0];
      REG_Q2:   q2_min    = val;
      REG_W2:   w2_min    = val;
      REG_YB:   yb_max    = val;
      REG_KIND: hadron    = val[0];
      REG_WPLN: w_plain   = val[0];
      REG_DEG:  phi_deg   = val[0];
      default:  edge_cnts = val[24:0];
    endcase
  endtask

  task automatic set_config(input logic [15:0] pid, input logic [31:0] q2c, w2c, ybc,
                            input logic kind, wpl, deg, input logic [24:0] ecnt);
    drain();
    write_reg(REG_PID, {16'd0, pid});
    write_reg(REG_Q2, q2c);
    write_reg(REG_W2, w2c);
    write_reg(REG_YB, ybc);
    write_reg(REG_KIND, {31'd0, kind});
    write_reg(REG_WPLN, {31'd0, wpl});
    write_reg(REG_DEG, {31'd0, deg});
    write_reg(REG_ECNT, {7'd0, ecnt});
    cfg_valid <= 0;
  endtask

  function automatic bin_req_t blank_req(input logic [1:0] cmd);
    bin_req_t r;
    r = '{cmd, 3'd0, 12'd0, 32'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
          32'sd0, 32'sd0, 32'sd0};
    return r;
  endfunction

  // edge i of every dimension sits at i.0
  task automatic load_edges;
    bin_req_t r;
    r = blank_req(CMD_WRITE);
    for (int d = 0; d < NUM_DIMS; d++)
      for (int i = 0; i < MAX_EDGES; i++) begin
        r.dim = 3'(d); r.slot = 12'(i); r.edge_value = i <<< 16;
        send_request(r);
      end
  endtask

  function automatic logic signed [31:0] in_bin(input int d);
    int n;
    n = bins_in(d);
    return ($urandom_range(n > 0 ? n - 1 : 0) <<< 16) + $urandom_range(1, 65535);
  endfunction

  function automatic bin_req_t good_event;
    bin_req_t r;
    r = blank_req(CMD_EVENT);
    r.pid = pid_sel;
    r.w_value = $urandom_range(2 << 16, 100 << 16);
    r.yb = $urandom_range(0, 50000);
    r.q2 = in_bin(0); r.nu = in_bin(1); r.zh = in_bin(2); r.pt2 = in_bin(3);
    r.phi = phi_deg ? $urandom_range(1, (bins_in(4) > 0 ? bins_in(4) : 1) * 3754936)
                    : in_bin(4);
    return r;
  endfunction

  function automatic bin_req_t noise_req;
    bin_req_t r;
    r = '{2'($urandom), 3'($urandom), 12'($urandom), $urandom, 16'($urandom), $urandom,
          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return r;
  endfunction

  task automatic run_random(input int count);
    bin_req_t r;
    int       k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99);
      if (k < 70) r = good_event();
      else if (k < 82) begin
        r = good_event();
        case ($urandom_range(8))
          0: r.pid = 16'(pid_sel + 1);
          1: r.q2 = q2_min - 1;
          2: r.w_value = $urandom_range(0, 2 << 16);
          3: r.yb = yb_max + 1;
          4: r.nu = 0;
          5: r.zh = 0;
          6: r.pt2 = 0;
          7: r.phi = 0;
          default: r.q2 = $urandom_range(1, 15) <<< 16;  // right on an edge
        endcase
      end else if (k < 90) begin
        r = blank_req(CMD_READ);
        r.slot = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(63));
      end else if (k < 96) begin
        r = blank_req(CMD_WRITE);
        r.dim = 3'($urandom_range(7)); r.slot = 12'($urandom_range(31));
        r.edge_value = r.slot <<< 16;
      end else r = noise_req();
      send_request(r);
    end
  endtask

  task automatic run_phase(input int idle, stall, count, input logic [15:0] pid,
                           input logic [31:0] q2c, w2c, ybc,
                           input logic kind, wpl, deg, input logic [24:0] ecnt);
    set_config(pid, q2c, w2c, ybc, kind, wpl, deg, ecnt);
    idle_pct = idle;
    stall_pct = stall;
    run_random(count);
  endtask

  task automatic test_directed_electron;
    bin_req_t r;
    set_config(16'd11, 32'd65536, 32'd262144, 32'd55706, 1'b0, 1'b0, 1'b0,
               {5'd2, 5'd2, 5'd2, 5'd5, 5'd6});
    load_edges();
    r = blank_req(CMD_EVENT);
    r.pid = 16'sd11; r.w_value = 5 << 16; r.yb = 30000; r.q2 = 32'h00018000;
    r.nu = 32'h00008000;
    send_request(r);
    send_request(r);
    begin bin_req_t b; b = blank_req(CMD_READ); b.slot = 5; send_request(b); end
    begin bin_req_t b; b = r; b.q2 = 65536;     send_request(b); end  // on an edge
    begin bin_req_t b; b = r; b.pid = -16'sd11; send_request(b); end
    begin bin_req_t b; b = r; b.nu = 0;         send_request(b); end
    begin bin_req_t b; b = r; b.yb = 55707;     send_request(b); end
    begin bin_req_t b; b = r; b.w_value = 262143; send_request(b); end
    begin bin_req_t b; b = blank_req(CMD_READ); b.slot = 12'hFFF; send_request(b); end
    begin
      bin_req_t b;
      b = blank_req(CMD_WRITE); b.dim = 5; b.slot = 0; b.edge_value = 32'h80000000;
      send_request(b);
      b.dim = 0; b.slot = 16; b.edge_value = 32'h7FFFFFFF;
      send_request(b);
    end
    send_request(blank_req(CMD_CLEAR));
    begin bin_req_t b; b = blank_req(CMD_READ); b.slot = 5; send_request(b); end
  endtask

  task automatic test_directed_hadron;
    bin_req_t r;
    set_config(16'd211, 32'd65536, 32'd262144, 32'd55706, 1'b1, 1'b1, 1'b1,
               {5'd4, 5'd3, 5'd3, 5'd3, 5'd4});
    r = blank_req(CMD_EVENT);
    r.pid = 16'sd211; r.w_value = 3 << 16; r.yb = 1000; r.q2 = 32'h00028000;
    r.nu = 32'h00018000; r.zh = 32'h00008000; r.pt2 = 32'h00014000; r.phi = 90 << 16;
    send_request(r);
    begin bin_req_t b; b = r; b.zh = 0;  send_request(b); end
    begin bin_req_t b; b = r; b.pt2 = 0; send_request(b); end
    begin bin_req_t b; b = r; b.phi = 0; send_request(b); end
    begin bin_req_t b; b = r; b.w_value = 32'h0001E666; send_request(b); end  // W^2 < 4
    begin bin_req_t b; b = r; b.w_value = 2 << 16;      send_request(b); end  // W^2 == 4
  endtask

  // result side holds off while requests keep coming
  task automatic test_backpressure;
    drain();
    idle_pct = 0;
    stall_pct = 0;
    hold_until <= cyc + 600;
    run_random(40);
  endtask

  initial begin
    foreach (bin_mem[i]) bin_mem[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 0;
    test_directed_electron();
    test_directed_hadron();
    run_phase(0, 0, 130, 16'd11, 32'd65536, 32'd262144, 32'd55706, 1'b0, 1'b0, 1'b0,
              {5'd2, 5'd2, 5'd2, 5'd5, 5'd6});
    run_phase(48, 0, 110, 16'd211, 32'd65536, 32'd262144, 32'd55706, 1'b1, 1'b0, 1'b0,
              {5'd4, 5'd3, 5'd3, 5'd3, 5'd4});
    run_phase(0, 48, 110, 16'hFF35, 32'd0, 32'd131072, 32'd60000, 1'b1, 1'b1, 1'b1,
              {5'd3, 5'd2, 5'd4, 5'd3, 5'd3});
    run_phase(19, 19, 90, 16'd11, 32'd65536, 32'd262144, 32'd55706, 1'b0, 1'b1, 1'b0,
              25'h1FFFFFF);
    run_phase(19, 19, 40, 16'h7FFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1'b1, 1'b0,
              1'b1, 25'd0);
    run_phase(19, 19, 40, 16'h8000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b0, 1'b1,
              1'b1, {5'd17, 5'd16, 5'd1, 5'd3, 5'd3});
    test_backpressure();
    drain();
    errors += expected_counts.size();
    if (errors == 0) $display("cut_and_bin_event_histogram_top test passed");
    else $display("cut_and_bin_event_histogram_top test failed");
    $finish;
  end
endmodule
